// ===== sv/olist_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
package olist_pkg;

  localparam int KIND_W  = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE_AT  = 3'd4,
    OP_REMOVE_VAL = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD,
    S_GOT,
    S_CL_RD,
    S_CL_WR,
    S_SU_RD,
    S_SU_WR,
    S_PF_WR,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_LAST,
    PTR_POS,
    PTR_INC,
    PTR_DEC
  } ptr_sel_e;

  typedef enum logic [1:0] {
    WR_FRONT,
    WR_TAIL,
    WR_UP,
    WR_DOWN
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_op;
    ptr_sel_e ptr_sel;
    logic     rd_next;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_miss;
    logic     set_full;
    logic     take;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  kind;
    logic empty;
    logic full;
    logic pos_ok;
    logic ptr_zero;
    logic ptr_last;
    logic ptr_prelast;
    logic match;
  } stat_t;

endpackage

// ===== sv/olist_req_if.sv =====
// Request channel: one list operation per beat.
// Depends on olist_pkg for field widths.
interface olist_req_if;
  import olist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [VAL_W-1:0]  value;
  logic [POS_W-1:0]         position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

// ===== sv/olist_rsp_if.sv =====
// Response channel: one result beat per list operation.
// Depends on olist_pkg for field widths.
interface olist_rsp_if;
  import olist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  removed_value;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, removed_value, status, entry_count, input ready);
  modport sink   (input valid, removed_value, status, entry_count, output ready);
endinterface

// ===== sv/olist_ctrl.sv =====
// Sequencer for the ordered list engine: walks the entry memory one step per state.
// Depends on olist_pkg for the state, command and status types.
module olist_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  olist_pkg::stat_t st_i,
  output olist_pkg::cmd_t  cmd_o
);
  import olist_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.ptr_sel  = PTR_HOLD;
    cmd_o.wr_sel   = WR_FRONT;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          state_d       = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (st_i.kind)
          OP_PUSH_FRONT: begin
            if (st_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_FINISH;
            end else if (st_i.empty) begin
              state_d = S_PF_WR;
            end else begin
              cmd_o.ptr_sel = PTR_LAST;
              state_d       = S_SU_RD;
            end
          end
          OP_PUSH_BACK: begin
            if (st_i.full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_TAIL;
              cmd_o.cnt_inc = 1'b1;
            end
            state_d = S_FINISH;
          end
          OP_POP_FRONT, OP_REMOVE_VAL: begin
            if (st_i.empty) begin
              cmd_o.set_miss = 1'b1;
              state_d        = S_FINISH;
            end else begin
              cmd_o.ptr_sel = PTR_ZERO;
              state_d       = S_RD;
            end
          end
          OP_POP_BACK: begin
            if (st_i.empty) begin
              cmd_o.set_miss = 1'b1;
              state_d        = S_FINISH;
            end else begin
              cmd_o.ptr_sel = PTR_LAST;
              state_d       = S_RD;
            end
          end
          OP_REMOVE_AT: begin
            if (!st_i.pos_ok) begin
              cmd_o.set_miss = 1'b1;
              state_d        = S_FINISH;
            end else begin
              cmd_o.ptr_sel = PTR_POS;
              state_d       = S_RD;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end

      S_RD: state_d = S_GOT;

      S_GOT: begin
        if (st_i.kind == OP_REMOVE_VAL && !st_i.match) begin
          // Scan miss on this entry: try the next one, or give up at the tail.
          if (st_i.ptr_last) begin
            cmd_o.set_miss = 1'b1;
            state_d        = S_FINISH;
          end else begin
            cmd_o.ptr_sel = PTR_INC;
            state_d       = S_RD;
          end
        end else begin
          cmd_o.take = 1'b1;
          if (st_i.ptr_last) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_FINISH;
          end else begin
            state_d = S_CL_RD;
          end
        end
      end

      S_CL_RD: begin
        cmd_o.rd_next = 1'b1;
        state_d       = S_CL_WR;
      end

      S_CL_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_DOWN;
        if (st_i.ptr_prelast) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.ptr_sel = PTR_INC;
          state_d       = S_CL_RD;
        end
      end

      S_SU_RD: state_d = S_SU_WR;

      S_SU_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_UP;
        if (st_i.ptr_zero) begin
          state_d = S_PF_WR;
        end else begin
          cmd_o.ptr_sel = PTR_DEC;
          state_d       = S_SU_RD;
        end
      end

      S_PF_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_FRONT;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/olist_dp.sv =====
// Datapath of the ordered list engine: entry memory, count, walk pointer,
// operation registers and the result register. Depends on olist_pkg.
module olist_dp #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [olist_pkg::KIND_W-1:0]      kind_i,
  input  logic signed [olist_pkg::VAL_W-1:0] value_i,
  input  logic [olist_pkg::POS_W-1:0]       position_i,
  output logic signed [olist_pkg::VAL_W-1:0] removed_value_o,
  output logic [olist_pkg::STAT_W-1:0]      status_o,
  output logic [olist_pkg::COUNT_W-1:0]     entry_count_o,
  input  olist_pkg::cmd_t                   cmd_i,
  output olist_pkg::stat_t                  st_o
);
  import olist_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  op_e               kind_q;
  logic [VAL_W-1:0]  val_q;
  logic [POS_W-1:0]  pos_q;
  logic [VAL_W-1:0]  rdata_q;
  logic [VAL_W-1:0]  removed_q;
  status_e           status_q;
  logic [VAL_W-1:0]  out_removed_q;
  status_e           out_status_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [VAL_W-1:0]  wdata;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     ptr_ext;

  assign cnt_m1  = cnt_q - CW'(1);
  assign ptr_ext = CW'(ptr_q);

  // Count is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_sel)
      PTR_ZERO: ptr_d = '0;
      PTR_LAST: ptr_d = AW'(cnt_m1);
      PTR_POS:  ptr_d = AW'(pos_q);
      PTR_INC:  ptr_d = ptr_q + AW'(1);
      PTR_DEC:  ptr_d = ptr_q - AW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  assign raddr = cmd_i.rd_next ? (ptr_q + AW'(1)) : ptr_q;

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_FRONT: begin
        waddr = '0;
        wdata = val_q;
      end
      WR_TAIL: begin
        waddr = AW'(cnt_q);
        wdata = val_q;
      end
      WR_UP: begin
        waddr = ptr_q + AW'(1);
        wdata = rdata_q;
      end
      default: begin
        waddr = ptr_q;
        wdata = rdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load_op) begin
      kind_q    <= op_e'(kind_i);
      val_q     <= value_i;
      pos_q     <= position_i;
      removed_q <= '0;
      status_q  <= ST_OK;
    end else begin
      if (cmd_i.take) begin
        removed_q <= rdata_q;
      end
      if (cmd_i.set_miss) begin
        status_q <= ST_MISS;
      end else if (cmd_i.set_full) begin
        status_q <= ST_FULL;
      end
    end
    if (cmd_i.out_load) begin
      out_removed_q <= removed_q;
      out_status_q  <= status_q;
      out_count_q   <= COUNT_W'(cnt_q);
    end
  end

  assign st_o.kind        = kind_q;
  assign st_o.empty       = (cnt_q == '0);
  assign st_o.full        = (cnt_q == CW'(DEPTH));
  assign st_o.pos_ok      = (CMPW'(pos_q) < CMPW'(cnt_q));
  assign st_o.ptr_zero    = (ptr_q == '0);
  assign st_o.ptr_last    = (ptr_ext == cnt_m1);
  assign st_o.ptr_prelast = ((ptr_ext + CW'(1)) == cnt_m1);
  assign st_o.match       = (rdata_q == val_q);

  assign removed_value_o = out_removed_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = out_count_q;

endmodule

// ===== sv/ordered_list_engine.sv =====
// Top level of the ordered list engine: controller plus datapath behind two channels.
// Depends on olist_pkg, olist_req_if, olist_rsp_if, olist_ctrl and olist_dp.
//
//   channel | dir | beat carries
//   --------+-----+------------------------------------------
//   req     | in  | kind, value, position
//   rsp     | out | removed_value, status, entry_count
//
// One operation at a time; the entry memory has one write and one read port.
// Push back, refused inserts and misses found at dispatch go from dispatch straight to the result.
// Pop back reads the tail; push front moves each entry up, then writes the front; other removals
// move each later entry down. Remove-by-value compares from the front; a miss compares every entry.
// Reset clears the control state and the count; entries are written before they are read.
// A request is taken while an earlier result waits; its result then holds until rsp drains.
module ordered_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  olist_req_if.sink          req,
  olist_rsp_if.source        rsp
);
  import olist_pkg::*;

  cmd_t  cmd;
  stat_t st;

  olist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  olist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (req.kind),
    .value_i         (req.value),
    .position_i      (req.position),
    .removed_value_o (rsp.removed_value),
    .status_o        (rsp.status),
    .entry_count_o   (rsp.entry_count),
    .cmd_i           (cmd),
    .st_o            (st)
  );

  // A refused insert reports a full list.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.entry_count == COUNT_W'(DEPTH)))
    else $error("full status with count below depth");

  // Only a successful removal carries a nonzero value.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.removed_value == '0))
    else $error("removed value on a failed operation");

  // The count never grows past the depth.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !st.full)
    else $error("count increment on a full list");

  // A result is never loaded in the cycle right after a request beat.
  a_dispatch_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !cmd.out_load)
    else $error("result loaded before dispatch");

endmodule
